[design/cdsp_pkg.sv]
// Shared types and constants for the countdown slot pool.
// Used by the channel interfaces, the front queue, the back engine and the top level.
`default_nettype none

package cdsp_pkg;

    localparam int DUR_W       = 32;
    localparam int RES_W       = 8;
    localparam int MASK_W      = 8;
    localparam int IDX_W       = 3;
    localparam int MODE_W      = 2;
    localparam int STATUS_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MODE_W-1:0] MODE_TICK  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_START = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BUSY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ZERO = 2'd2;

    localparam logic [RES_W-1:0] RES_RESET = 8'd1;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_START,
        OP_CLEAR,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [DUR_W-1:0] duration;
    } t_item;

endpackage

`default_nettype wire

[design/cdsp_if.sv]
// Valid/ready channel interfaces for command items and result items.
// Depends on cdsp_pkg for the field widths.
`default_nettype none

interface cdsp_in_if
    import cdsp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [DUR_W-1:0]  duration_us;

    modport source (output valid, output mode, output duration_us, input ready);
    modport sink   (input valid, input mode, input duration_us, output ready);
endinterface

interface cdsp_out_if
    import cdsp_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    slot_index;
    logic [MASK_W-1:0]   expired_mask;

    modport source (output valid, output status, output slot_index, output expired_mask,
                    input ready);
    modport sink   (input valid, input status, input slot_index, input expired_mask,
                    output ready);
endinterface

`default_nettype wire

[design/cdsp_front.sv]
// Front part: accepts command items, classifies the mode and holds them in a short queue.
// Depends on cdsp_pkg and cdsp_in_if.
`default_nettype none

module cdsp_front
    import cdsp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    cdsp_in_if.sink    i_item,
    output t_item      o_head,
    output logic       o_head_valid,
    input  wire logic  i_head_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item            r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push;
    logic             pop;
    t_item            class_item;

    always_comb begin
        class_item.duration = i_item.duration_us;
        unique case (i_item.mode)
            MODE_TICK:  class_item.op = OP_TICK;
            MODE_START: class_item.op = OP_START;
            MODE_CLEAR: class_item.op = OP_CLEAR;
            default:    class_item.op = OP_NONE;
        endcase
    end

    assign i_item.ready = (r_cnt != CNT_W'(QUEUE_DEPTH));
    assign push         = i_item.valid && i_item.ready;
    assign o_head_valid = (r_cnt != '0);
    assign pop          = o_head_valid && i_head_pop;
    assign o_head       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_mem[r_wr] <= class_item;
                r_wr        <= (r_wr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

[design/cdsp_back.sv]
// Back part: slot store, bit-serial ceiling divider and result register.
// Depends on cdsp_pkg and cdsp_out_if; takes items from cdsp_front.
`default_nettype none

module cdsp_back
    import cdsp_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [RES_W-1:0] i_resolution,
    input  wire t_item            i_head,
    input  wire logic             i_head_valid,
    output logic                  o_head_pop,
    cdsp_out_if.source            o_result
);

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int CNT_W  = $clog2(DUR_W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state                r_state;
    logic [NUM_SLOTS-1:0]  r_busy;
    logic [DUR_W-1:0]      r_ticks [NUM_SLOTS];
    logic [SLOT_W-1:0]     r_slot;
    logic [DUR_W-1:0]      r_quo;
    logic [RES_W-1:0]      r_rem;
    logic [RES_W-1:0]      r_div;
    logic [CNT_W-1:0]      r_cnt;
    logic                  r_o_valid;
    logic [STATUS_W-1:0]   r_o_status;
    logic [IDX_W-1:0]      r_o_index;
    logic [MASK_W-1:0]     r_o_mask;

    logic                  out_free;
    logic                  result_load;
    logic                  have_free;
    logic [SLOT_W-1:0]     found;
    logic [NUM_SLOTS-1:0]  expire;
    logic [NUM_SLOTS-1:0]  busy_zero;
    logic [NUM_SLOTS+MASK_W-1:0] expire_ext;
    logic [SLOT_W+IDX_W-1:0]     slot_ext;
    logic [RES_W:0]        rem_sh;
    logic [RES_W:0]        rem_sub;
    logic                  ge;
    logic [RES_W-1:0]      n_rem;
    logic [DUR_W-1:0]      n_quo;
    logic [DUR_W-1:0]      ticks_final;
    logic [RES_W-1:0]      div_eff;

    assign out_free   = !r_o_valid || o_result.ready;
    assign o_head_pop = (r_state == S_IDLE) && i_head_valid && out_free;

    assign result_load = (o_head_pop && !((i_head.op == OP_START) && have_free))
                      || ((r_state == S_FIN) && out_free);

    always_comb begin
        have_free = 1'b0;
        found     = '0;
        for (int s = NUM_SLOTS - 1; s >= 0; s--) begin
            if (!r_busy[s]) begin
                have_free = 1'b1;
                found     = SLOT_W'(s);
            end
        end
    end

    always_comb begin
        for (int s = 0; s < NUM_SLOTS; s++) begin
            expire[s]    = r_busy[s] && (r_ticks[s] == DUR_W'(1));
            busy_zero[s] = r_busy[s] && (r_ticks[s] == '0);
        end
    end

    assign expire_ext = {{MASK_W{1'b0}}, expire};
    assign slot_ext   = {{IDX_W{1'b0}}, r_slot};

    assign div_eff     = (i_resolution == '0) ? RES_W'(1) : i_resolution;
    assign rem_sh      = {r_rem, r_quo[DUR_W-1]};
    assign rem_sub     = rem_sh - {1'b0, r_div};
    assign ge          = (rem_sh >= {1'b0, r_div});
    assign n_rem       = ge ? rem_sub[RES_W-1:0] : rem_sh[RES_W-1:0];
    assign n_quo       = {r_quo[DUR_W-2:0], ge};
    assign ticks_final = r_quo + DUR_W'(r_rem != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_busy    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (result_load) begin
                r_o_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_head_pop) begin
                        unique case (i_head.op)
                            OP_TICK: begin
                                for (int s = 0; s < NUM_SLOTS; s++) begin
                                    if (r_busy[s]) begin
                                        r_ticks[s] <= r_ticks[s] - 1'b1;
                                    end
                                    if (expire[s]) begin
                                        r_busy[s] <= 1'b0;
                                    end
                                end
                                r_o_status <= ST_OK;
                                r_o_index  <= '0;
                                r_o_mask   <= expire_ext[MASK_W-1:0];
                            end
                            OP_CLEAR: begin
                                r_busy     <= '0;
                                r_o_status <= ST_OK;
                                r_o_index  <= '0;
                                r_o_mask   <= '0;
                            end
                            OP_START: begin
                                if (!have_free) begin
                                    r_o_status <= ST_BUSY;
                                    r_o_index  <= '0;
                                    r_o_mask   <= '0;
                                end else begin
                                    r_slot  <= found;
                                    r_quo   <= i_head.duration;
                                    r_rem   <= '0;
                                    r_div   <= div_eff;
                                    r_cnt   <= '0;
                                    r_state <= S_DIV;
                                end
                            end
                            default: begin
                                r_o_status <= ST_OK;
                                r_o_index  <= '0;
                                r_o_mask   <= '0;
                            end
                        endcase
                    end
                end
                S_DIV: begin
                    r_quo <= n_quo;
                    r_rem <= n_rem;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(DUR_W - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        r_o_mask <= '0;
                        if (ticks_final == '0) begin
                            r_o_status <= ST_ZERO;
                            r_o_index  <= '0;
                        end else begin
                            r_busy[r_slot]  <= 1'b1;
                            r_ticks[r_slot] <= ticks_final;
                            r_o_status      <= ST_OK;
                            r_o_index       <= slot_ext[IDX_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_result.valid        = r_o_valid;
    assign o_result.status       = r_o_status;
    assign o_result.slot_index   = r_o_index;
    assign o_result.expired_mask = r_o_mask;

    a_pop_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_head_pop |-> (r_state == S_IDLE))
        else $error("Item taken from the queue while the engine is busy.");

    a_div_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt == CNT_W'(DUR_W - 1)) |=> (r_state == S_FIN))
        else $error("Division did not finish after its last step.");

    a_busy_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy_zero == '0)
        else $error("A busy slot holds a zero count.");

    a_fin_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && out_free) |=> (r_o_valid && r_state == S_IDLE))
        else $error("A finished start gave no result.");

endmodule

`default_nettype wire

[design/countdown_slot_pool.sv]
// Top level of the countdown slot pool: resolution register, front queue and back engine.
// Depends on cdsp_pkg, cdsp_if, cdsp_front and cdsp_back.
//
// Each item gives one result. A tick, a clear, an unused mode or a start that finds every
// slot busy passes through the front queue and then into the result register of the back
// engine. A start that finds a free slot runs the bit-serial divider, which forms the
// ceiling of the duration over the resolution one quotient bit per cycle; the engine then
// loads the slot once the result register is free. The two-entry queue lets new items be
// accepted while the engine divides or while a result waits to be taken. Write the
// resolution register only while the block is idle; a value of zero acts as one.
`default_nettype none

module countdown_slot_pool
    import cdsp_pkg::*;
#(
    parameter int NUM_SLOTS = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [RES_W-1:0] i_cfg_data,
    cdsp_in_if.sink               i_item,
    cdsp_out_if.source            o_result
);

    logic [RES_W-1:0] r_resolution;
    t_item            head;
    logic             head_valid;
    logic             head_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_resolution <= RES_RESET;
        end else if (i_cfg_we) begin
            r_resolution <= i_cfg_data;
        end
    end

    cdsp_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (i_item),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_head_pop   (head_pop)
    );

    cdsp_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_resolution (r_resolution),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_head_pop   (head_pop),
        .o_result     (o_result)
    );

endmodule

`default_nettype wire
